// File: rtl/size_class_block_allocator_defines.svh
// Assertion macros shared by the checker.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH
`define SCBA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: implication failed");
`define SCBA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");
`endif

// File: rtl/scba_pkg.sv
`timescale 1ns / 1ps
package scba_pkg;
    localparam int NUM_CHUNKS_D = 16;
    localparam int CHUNK_LOG2_D = 18;
    localparam int PAGE_LOG2_D  = 16;
    localparam int NUM_CLASSES  = 24;
    localparam int MAX_REQUEST  = 32768;
    localparam logic [4:0] OWNER_NONE = 5'd31;

    typedef enum logic [1:0] {
        ST_SERVED   = 2'd0,
        ST_FALLBACK = 2'd1,
        ST_NULL     = 2'd2,
        ST_UNASSIGN = 2'd3
    } t_status;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_DECIDE, S_SEARCH, S_CARVE, S_LINK, S_POP, S_OUT
    } t_state;

    function automatic logic [15:0] block_bytes(input logic [4:0] c);
        logic [15:0] b;
        unique case (c)
            5'd0: b = 16'd8;      5'd1: b = 16'd16;     5'd2: b = 16'd24;
            5'd3: b = 16'd32;     5'd4: b = 16'd48;     5'd5: b = 16'd64;
            5'd6: b = 16'd96;     5'd7: b = 16'd128;    5'd8: b = 16'd192;
            5'd9: b = 16'd256;    5'd10: b = 16'd384;   5'd11: b = 16'd512;
            5'd12: b = 16'd768;   5'd13: b = 16'd1024;  5'd14: b = 16'd1536;
            5'd15: b = 16'd2048;  5'd16: b = 16'd3072;  5'd17: b = 16'd4096;
            5'd18: b = 16'd6144;  5'd19: b = 16'd8192;  5'd20: b = 16'd12288;
            5'd21: b = 16'd16384; 5'd22: b = 16'd24576; 5'd23: b = 16'd32768;
            default: b = 16'd8;
        endcase
        return b;
    endfunction

    function automatic logic [4:0] class_of(input logic [15:0] size);
        logic [4:0] c;
        c = 5'd23;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if ({1'b0, size} <= {1'b0, block_bytes(5'(k))}) begin
                c = 5'(k);
            end
        end
        return c;
    endfunction
endpackage

// File: rtl/scba_if.sv
`timescale 1ns / 1ps
interface scba_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] request_size;
    logic [31:0] release_address;
    modport source (output valid, command, request_size, release_address, input ready);
    modport sink (input valid, command, request_size, release_address, output ready);
endinterface

interface scba_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_address;
    logic [1:0]  status;
    logic [4:0]  size_class;
    modport source (output valid, block_address, status, size_class, input ready);
    modport sink (input valid, block_address, status, size_class, output ready);
endinterface

// File: rtl/size_class_block_allocator.sv
`timescale 1ns / 1ps
// Size-class block allocator.
// Requests arrive on i_req (valid/ready); each one gives exactly one response
// on o_rsp. Command 0 allocates request_size bytes, command 1 releases
// release_address. arena_base is written through i_cfg_we/i_cfg_data; the user
// must write it only while the block is idle, which the block leaves unchecked.
// One request is handled at a time. A request that hits a nonempty free list
// or a release into an assigned chunk passes S_HEAD, S_DECIDE, S_POP and S_OUT,
// its response turning valid as it leaves S_OUT. An oversize allocation, a null
// release or a release outside the arena answers in the cycle after acceptance,
// and a release into an unassigned chunk answers as it leaves S_DECIDE.
// An allocation that must refill first scans the chunk table one chunk a cycle
// and then writes one link word a cycle for each block of the carved page,
// since the link memory has a single write port.
// Reset empties every free list and marks every chunk unassigned and
// uncarved; the link memory needs no clearing because an entry is only used after
// a write. A response is held in its output register until taken; while the
// receiver stalls no new request is accepted. The next request is accepted
// in the cycle after the response is taken.
module size_class_block_allocator #(
    parameter int NUM_CHUNKS = scba_pkg::NUM_CHUNKS_D,
    parameter int CHUNK_LOG2 = scba_pkg::CHUNK_LOG2_D,
    parameter int PAGE_LOG2  = scba_pkg::PAGE_LOG2_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    scba_req_if.sink    i_req,
    scba_rsp_if.source  o_rsp
);
    import scba_pkg::*;

    localparam int IDXW   = $clog2(NUM_CHUNKS) + CHUNK_LOG2 - 3;
    localparam int DEPTH  = NUM_CHUNKS << (CHUNK_LOG2 - 3);
    localparam int CW     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int PPC    = 1 << (CHUNK_LOG2 - PAGE_LOG2);
    localparam int PGW    = CHUNK_LOG2 - PAGE_LOG2 + 1;
    localparam int POFFW  = PAGE_LOG2 - 3;
    localparam logic [32:0] ARENA_BYTES = 33'(NUM_CHUNKS) << CHUNK_LOG2;

    typedef logic [IDXW:0] t_ptr;

    t_state r_state, n_state;
    logic [31:0] r_base;
    t_ptr  r_head [NUM_CLASSES];
    logic [4:0] r_owner [NUM_CHUNKS];
    logic [PGW-1:0] r_page [NUM_CHUNKS];
    t_ptr  r_link [DEPTH];

    logic r_cmd;
    logic [4:0] r_cls;
    logic [31:0] r_off;
    t_ptr r_hd;
    logic [CW-1:0] r_k;
    logic [POFFW:0] r_delta;
    logic [IDXW-1:0] r_pbase;
    t_ptr r_prev;
    t_ptr r_rd;
    logic r_ov;
    logic [31:0] r_oaddr;
    logic [1:0] r_ostat;
    logic [4:0] r_ocls;

    logic [15:0] bs;
    logic [POFFW:0] bs_slots;
    logic [15:0] eff_size;
    logic chunk_ok;
    logic [IDXW-1:0] cur_idx;
    logic last_blk;
    logic imm_done;

    assign bs = block_bytes(r_cls);
    assign bs_slots = (POFFW + 1)'(bs >> 3);
    assign eff_size = (i_req.request_size == 16'd0) ? 16'd1 : i_req.request_size;
    assign chunk_ok = (r_owner[r_k] == r_cls || r_owner[r_k] == OWNER_NONE)
                      && (r_page[r_k] < PGW'(PPC));
    assign cur_idx = r_pbase + IDXW'(r_delta);
    assign last_blk = ({1'b0, r_delta} + {1'b0, bs_slots} + {1'b0, bs_slots})
                      > (POFFW + 2)'(1 << POFFW);
    assign imm_done = (i_req.command == CMD_ALLOC) ? (eff_size > 16'(MAX_REQUEST))
                      : (i_req.release_address == 32'd0
                         || {1'b0, i_req.release_address - r_base} >= ARENA_BYTES);

    assign i_req.ready = (r_state == S_IDLE) && !r_ov;
    assign o_rsp.valid = r_ov;
    assign o_rsp.block_address = r_oaddr;
    assign o_rsp.status = r_ostat;
    assign o_rsp.size_class = r_ocls;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_req.valid && i_req.ready && !imm_done) n_state = S_HEAD;
            S_HEAD:   n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_cmd == CMD_RELEASE && r_cls >= 5'(NUM_CLASSES)) n_state = S_IDLE;
                else if (r_cmd == CMD_RELEASE || r_hd[IDXW]) n_state = S_POP;
                else n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (chunk_ok) n_state = S_CARVE;
                else if (32'(r_k) == NUM_CHUNKS - 1) n_state = S_OUT;
            end
            S_CARVE:  if (last_blk) n_state = S_LINK;
            S_LINK:   n_state = S_POP;
            S_POP:    n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base <= '0;
            r_ov <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) r_head[i] <= '0;
            for (int i = 0; i < NUM_CHUNKS; i++) begin
                r_owner[i] <= OWNER_NONE;
                r_page[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_base <= i_cfg_data;
            if (o_rsp.valid && o_rsp.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_cmd <= i_req.command;
                        r_cls <= (eff_size > 16'(MAX_REQUEST)) ? 5'd0 : class_of(eff_size);
                        r_off <= i_req.release_address - r_base;
                        r_oaddr <= '0;
                        r_ostat <= (i_req.command == CMD_RELEASE
                                    && i_req.release_address == 32'd0)
                                   ? ST_NULL : ST_FALLBACK;
                        r_ocls <= 5'd0;
                        r_k <= '0;
                        if (imm_done) r_ov <= 1'b1;
                    end
                end
                S_HEAD: begin
                    if (r_cmd == CMD_RELEASE) begin
                        r_cls <= r_owner[CW'(r_off >> CHUNK_LOG2)];
                    end
                    r_hd <= r_head[r_cls];
                end
                S_DECIDE: begin
                    if (r_cmd == CMD_RELEASE) begin
                        if (r_cls >= 5'(NUM_CLASSES)) begin
                            r_ostat <= ST_UNASSIGN;
                            r_ov <= 1'b1;
                        end else begin
                            r_hd <= r_head[r_cls];
                        end
                    end else begin
                        r_ocls <= r_cls;
                    end
                end
                S_SEARCH: begin
                    if (chunk_ok) begin
                        r_owner[r_k] <= r_cls;
                        r_page[r_k] <= r_page[r_k] + PGW'(1);
                        r_pbase <= IDXW'(({32'd0, 32'(r_k)} << (CHUNK_LOG2 - 3))
                                   + (32'(r_page[r_k]) << POFFW));
                        r_delta <= '0;
                        r_prev <= '0;
                    end else if (32'(r_k) != NUM_CHUNKS - 1) begin
                        r_k <= r_k + CW'(1);
                    end
                end
                S_CARVE: begin
                    r_prev <= {1'b1, cur_idx};
                    r_delta <= r_delta + bs_slots;
                end
                S_LINK: begin
                    r_hd <= r_prev;
                end
                S_POP: begin
                    if (r_cmd == CMD_RELEASE) begin
                        r_head[r_cls] <= {1'b1, IDXW'(r_off >> 3)};
                        r_ostat <= ST_SERVED;
                        r_ocls <= r_cls;
                    end else begin
                        r_oaddr <= r_base + 32'({r_hd[IDXW-1:0], 3'b000});
                        r_ostat <= ST_SERVED;
                        r_ocls <= r_cls;
                    end
                end
                S_OUT: begin
                    if (r_cmd == CMD_ALLOC && r_ostat == ST_SERVED) begin
                        r_head[r_cls] <= r_rd;
                    end
                    r_ov <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CARVE) begin
            r_link[cur_idx] <= r_prev;
        end else if (r_state == S_POP && r_cmd == CMD_RELEASE) begin
            r_link[IDXW'(r_off >> 3)] <= r_hd;
        end
        r_rd <= r_link[r_hd[IDXW-1:0]];
    end
endmodule

// File: rtl/scba_checker.sv
`timescale 1ns / 1ps
`include "size_class_block_allocator_defines.svh"
module scba_assert_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_addr,
    input logic [1:0]  rsp_status
);
    import scba_pkg::*;

    `SCBA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_addr))
    `SCBA_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, rsp_valid, !req_ready)
    `SCBA_ASSERT_IMPL(a_addr_zero, i_clk, i_rst_n, rsp_valid && rsp_status != ST_SERVED, rsp_addr == 32'd0)
    `SCBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, req_valid && req_ready, !req_ready)
endmodule

bind size_class_block_allocator scba_assert_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .rsp_addr(o_rsp.block_address), .rsp_status(o_rsp.status)
);
